@@ sv/msm_pkg.sv @@
// Shared constants, codes and types of the multi-stack shared memory block.
`timescale 1ns / 1ps

package msm_pkg;

  localparam int MEM_DEPTH_DEF  = 1024;
  localparam int MAX_STACKS_DEF = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int NUM_W      = 4;
  localparam int CAP_W      = 8;
  localparam int IDX_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [NUM_W-1:0] NUM_STACKS_RST = NUM_W'(3);
  localparam logic [CAP_W-1:0] INIT_CAP_RST   = CAP_W'(4);

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STACKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP   = CFG_IDX_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK,
    STATUS_BAD_INDEX,
    STATUS_EMPTY,
    STATUS_FULL
  } status_e;

  typedef enum logic {
    OP_PUSH,
    OP_POP
  } op_e;

  typedef struct packed {
    logic             reload;
    logic [NUM_W-1:0] num;
    logic [CAP_W-1:0] init;
  } cfg_t;

endpackage

@@ sv/msm_if.sv @@
// Request and response channel interfaces of the multi-stack shared memory block.
`timescale 1ns / 1ps

interface msm_req_if #(
  parameter int DATA_WIDTH = msm_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  msm_pkg::op_e                 operation;
  logic [msm_pkg::IDX_W-1:0]    stack_index;
  logic signed [DATA_WIDTH-1:0] push_value;

  modport source (output valid, operation, stack_index, push_value, input ready);
  modport sink (input valid, operation, stack_index, push_value, output ready);
endinterface

interface msm_rsp_if #(
  parameter int DATA_WIDTH = msm_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  msm_pkg::status_e             status;
  logic signed [DATA_WIDTH-1:0] pop_value;
  logic                         grew;

  modport source (output valid, status, pop_value, grew, input ready);
  modport sink (input valid, status, pop_value, grew, output ready);
endinterface

@@ sv/msm_engine.sv @@
// Sequencer, shared multiply-add unit, entry memory and depth registers of the stacks.
`timescale 1ns / 1ps

module msm_engine #(
  parameter int MEM_DEPTH  = msm_pkg::MEM_DEPTH_DEF,
  parameter int MAX_STACKS = msm_pkg::MAX_STACKS_DEF,
  parameter int DATA_WIDTH = msm_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  msm_pkg::cfg_t cfg_i,
  msm_req_if.sink       req_i,
  msm_rsp_if.source     rsp_o
);

  localparam int AW  = $clog2(MEM_DEPTH);
  localparam int CW  = $clog2(MEM_DEPTH + 1);
  localparam int SW  = $clog2(MAX_STACKS);
  localparam int NW  = $clog2(MAX_STACKS + 1);
  localparam int KW  = msm_pkg::IDX_W;
  localparam int NMW = msm_pkg::NUM_W;
  localparam int CIW = msm_pkg::CAP_W;
  localparam int BW  = $clog2(CIW);
  localparam int EW0 = (NW > NMW) ? NW : NMW;
  localparam int EW  = (EW0 > KW) ? EW0 : KW;
  localparam int XW  = (SW > KW) ? SW : KW;
  localparam int UBW = ((CW + 1) > CIW) ? (CW + 1) : CIW;
  localparam int RW  = EW + UBW + 1;

  typedef enum logic [3:0] {
    S_RELOAD,
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_BASE,
    S_PTR,
    S_MOVE_RD,
    S_MOVE_WR,
    S_ADDR,
    S_ACCESS,
    S_DONE
  } state_e;

  state_e                  state_q;
  msm_pkg::op_e            op_q;
  logic [KW-1:0]           k_q;
  logic [DATA_WIDTH-1:0]   val_q;
  logic [CW-1:0]           cap_q;
  logic [CW-1:0]           old_cap_q;
  logic [SW-1:0]           j_q;
  logic [CIW-1:0]          q_q;
  logic [BW-1:0]           bit_q;
  logic [RW-1:0]           acc_q;
  logic [CW-1:0]           cnt_q;
  logic [RW-1:0]           src_q;
  logic [RW-1:0]           dst_q;
  msm_pkg::status_e        res_status_q;
  logic                    res_grew_q;
  logic                    use_rd_q;
  logic                    out_valid_q;
  msm_pkg::status_e        out_status_q;
  logic [DATA_WIDTH-1:0]   out_pop_q;
  logic                    out_grew_q;
  logic [CW-1:0]           depths_q [MAX_STACKS];
  logic [DATA_WIDTH-1:0]   mem_q [MEM_DEPTH];
  logic [DATA_WIDTH-1:0]   rdata_q;

  logic [EW-1:0]         n_act;
  logic [EW-1:0]         n_one;
  logic [EW-1:0]         n_m1;
  logic [EW-1:0]         num_ext;
  logic [EW-1:0]         kx;
  logic [XW-1:0]         k_w;
  logic [SW-1:0]         k_idx;
  logic [SW-1:0]         didx;
  logic [CW-1:0]         d_sel;
  logic [CIW-1:0]        cap_init;
  logic [CIW-1:0]        trial;
  logic [EW-1:0]         ua;
  logic [UBW-1:0]        ub;
  logic [CW-1:0]         uc;
  logic [RW-1:0]         prod;
  logic                  fits;
  logic                  acc_in_range;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  out_free;
  logic                  out_load;

  assign num_ext  = EW'(cfg_i.num);
  assign n_act    = (num_ext > EW'(MAX_STACKS)) ? EW'(MAX_STACKS) : num_ext;
  assign n_one    = (n_act == '0) ? EW'(1) : n_act;
  assign n_m1     = n_act - EW'(1);
  assign kx       = EW'(k_q);
  assign k_w      = XW'(k_q);
  assign k_idx    = k_w[SW-1:0];
  assign cap_init = (cfg_i.init == '0) ? CIW'(1) : cfg_i.init;
  assign trial    = q_q | (CIW'(1) << bit_q);
  assign didx     = (state_q == S_BASE) ? j_q : k_idx;
  assign d_sel    = depths_q[didx];
  assign acc_in_range = acc_q < RW'(MEM_DEPTH);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign out_load = !cfg_i.reload && (state_q == S_DONE) && out_free;

  always_comb begin
    ua = '0;
    ub = '0;
    uc = '0;
    case (state_q)
      S_RELOAD: begin
        ua = n_one;
        ub = UBW'(trial);
      end
      S_CHECK: begin
        ua = n_act;
        ub = UBW'({cap_q, 1'b0});
      end
      S_BASE: begin
        ua = EW'(j_q);
        ub = UBW'(old_cap_q);
      end
      S_ADDR: begin
        ua = kx;
        ub = UBW'(cap_q);
        uc = (op_q == msm_pkg::OP_POP) ? d_sel - CW'(1) : d_sel;
      end
      default: begin
        ua = '0;
      end
    endcase
    prod = RW'(ua) * RW'(ub) + RW'(uc);
  end

  assign fits = (prod <= RW'(MEM_DEPTH)) && (trial <= cap_init);

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = acc_q[AW-1:0];
    mem_raddr = acc_q[AW-1:0];
    mem_wdata = val_q;
    case (state_q)
      S_MOVE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = src_q[AW-1:0];
      end
      S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dst_q[AW-1:0];
        mem_wdata = rdata_q;
      end
      S_ACCESS: begin
        mem_we = (op_q == msm_pkg::OP_PUSH) && acc_in_range;
        mem_re = (op_q == msm_pkg::OP_POP);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_RELOAD;
      op_q         <= msm_pkg::OP_PUSH;
      k_q          <= '0;
      val_q        <= '0;
      cap_q        <= '0;
      old_cap_q    <= '0;
      j_q          <= '0;
      q_q          <= '0;
      bit_q        <= BW'(CIW - 1);
      acc_q        <= '0;
      cnt_q        <= '0;
      src_q        <= '0;
      dst_q        <= '0;
      res_status_q <= msm_pkg::STATUS_OK;
      res_grew_q   <= 1'b0;
      use_rd_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= msm_pkg::STATUS_OK;
      out_pop_q    <= '0;
      out_grew_q   <= 1'b0;
      for (int i = 0; i < MAX_STACKS; i++) begin
        depths_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && rsp_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.reload) begin
        state_q <= S_RELOAD;
        q_q     <= '0;
        bit_q   <= BW'(CIW - 1);
        for (int i = 0; i < MAX_STACKS; i++) begin
          depths_q[i] <= '0;
        end
      end else begin
        case (state_q)
          S_RELOAD: begin
            if (fits) begin
              q_q <= trial;
            end
            if (bit_q == '0) begin
              cap_q   <= fits ? CW'(trial) : CW'(q_q);
              state_q <= S_IDLE;
            end else begin
              bit_q <= bit_q - BW'(1);
            end
          end
          S_IDLE: begin
            if (req_i.valid) begin
              op_q         <= req_i.operation;
              k_q          <= req_i.stack_index;
              val_q        <= req_i.push_value;
              res_status_q <= msm_pkg::STATUS_OK;
              res_grew_q   <= 1'b0;
              use_rd_q     <= 1'b0;
              state_q      <= S_DECODE;
            end
          end
          S_DECODE: begin
            if (kx >= n_act) begin
              res_status_q <= msm_pkg::STATUS_BAD_INDEX;
              state_q      <= S_DONE;
            end else if (op_q == msm_pkg::OP_POP) begin
              if (d_sel == '0) begin
                res_status_q <= msm_pkg::STATUS_EMPTY;
                state_q      <= S_DONE;
              end else begin
                state_q <= S_ADDR;
              end
            end else if (d_sel >= cap_q) begin
              state_q <= S_CHECK;
            end else begin
              state_q <= S_ADDR;
            end
          end
          S_CHECK: begin
            if (prod > RW'(MEM_DEPTH)) begin
              res_status_q <= msm_pkg::STATUS_FULL;
              state_q      <= S_DONE;
            end else begin
              old_cap_q  <= cap_q;
              cap_q      <= CW'({cap_q, 1'b0});
              j_q        <= n_m1[SW-1:0];
              res_grew_q <= 1'b1;
              state_q    <= S_BASE;
            end
          end
          S_BASE: begin
            acc_q   <= prod;
            cnt_q   <= d_sel;
            state_q <= S_PTR;
          end
          S_PTR: begin
            if (cnt_q == '0) begin
              if (j_q == '0) begin
                state_q <= S_ADDR;
              end else begin
                j_q     <= j_q - SW'(1);
                state_q <= S_BASE;
              end
            end else begin
              src_q   <= acc_q + RW'(cnt_q) - RW'(1);
              dst_q   <= (acc_q << 1) + RW'(cnt_q) - RW'(1);
              state_q <= S_MOVE_RD;
            end
          end
          S_MOVE_RD: begin
            state_q <= S_MOVE_WR;
          end
          S_MOVE_WR: begin
            cnt_q <= cnt_q - CW'(1);
            src_q <= src_q - RW'(1);
            dst_q <= dst_q - RW'(1);
            if (cnt_q != CW'(1)) begin
              state_q <= S_MOVE_RD;
            end else if (j_q == '0) begin
              state_q <= S_ADDR;
            end else begin
              j_q     <= j_q - SW'(1);
              state_q <= S_BASE;
            end
          end
          S_ADDR: begin
            acc_q   <= prod;
            state_q <= S_ACCESS;
          end
          S_ACCESS: begin
            if (op_q == msm_pkg::OP_POP) begin
              depths_q[k_idx] <= d_sel - CW'(1);
              use_rd_q        <= 1'b1;
            end else begin
              depths_q[k_idx] <= d_sel + CW'(1);
            end
            state_q <= S_DONE;
          end
          S_DONE: begin
            if (out_free) begin
              out_valid_q  <= 1'b1;
              out_status_q <= res_status_q;
              out_pop_q    <= use_rd_q ? rdata_q : '1;
              out_grew_q   <= res_grew_q;
              state_q      <= S_IDLE;
            end
          end
          default: begin
            state_q <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign req_i.ready     = (state_q == S_IDLE) && !cfg_i.reload;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.pop_value = out_pop_q;
  assign rsp_o.grew      = out_grew_q;

endmodule

@@ sv/multi_stack_shared_memory_top.sv @@
// Top level of the multi-stack shared memory block with its configuration registers.
//
//   Channel   Direction  Beat contents
//   req_i     in         operation, stack_index, push_value
//   rsp_o     out        status, pop_value, grew
//   cfg       in         cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// A push or pop without growth passes the decode, address and access states; a bad index or an
// empty pop goes from decode straight to the done state. A push that doubles the capacity adds
// a check state, a base and a pointer state for each stack in use and a read and a write state
// for every stored entry, since each entry moves through the memory with a registered read.
// After reset and after each write to the stack count or initial capacity, a capacity search
// on the shared multiply-add unit runs before the first beat is accepted.
// A result waits in the output register while the next request is accepted and worked on.
`timescale 1ns / 1ps

module multi_stack_shared_memory_top #(
  parameter int MEM_DEPTH  = msm_pkg::MEM_DEPTH_DEF,
  parameter int MAX_STACKS = msm_pkg::MAX_STACKS_DEF,
  parameter int DATA_WIDTH = msm_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  msm_req_if.sink                         req_i,
  msm_rsp_if.source                       rsp_o,
  input  logic                            cfg_we_i,
  input  logic [msm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [msm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic [msm_pkg::NUM_W-1:0] num_q;
  logic [msm_pkg::CAP_W-1:0] init_q;
  logic                      wr_num;
  logic                      wr_init;
  msm_pkg::cfg_t             cfg;

  assign wr_num  = cfg_we_i && (cfg_idx_i == msm_pkg::CFG_NUM_STACKS);
  assign wr_init = cfg_we_i && (cfg_idx_i == msm_pkg::CFG_INIT_CAP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= msm_pkg::NUM_STACKS_RST;
      init_q <= msm_pkg::INIT_CAP_RST;
    end else begin
      if (wr_num) begin
        num_q <= cfg_wdata_i[msm_pkg::NUM_W-1:0];
      end
      if (wr_init) begin
        init_q <= cfg_wdata_i[msm_pkg::CAP_W-1:0];
      end
    end
  end

  assign cfg.reload = wr_num || wr_init;
  assign cfg.num    = num_q;
  assign cfg.init   = init_q;

  msm_engine #(
    .MEM_DEPTH  (MEM_DEPTH),
    .MAX_STACKS (MAX_STACKS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
